FILE: design/address_range_to_prefix_blocks_defines.svh
// Assertion macros shared by the address range to prefix block expansion RTL.
`ifndef ADDRESS_RANGE_TO_PREFIX_BLOCKS_DEFINES_SVH
`define ADDRESS_RANGE_TO_PREFIX_BLOCKS_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ARP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ARP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: design/arp_pkg.sv
// Package with the shared types and helper functions of the prefix block expansion.
`default_nettype none

package arp_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned PFX_W  = 6;
    localparam int unsigned LOG_W  = 5;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic in_zero;
        logic last;
    } t_stat;

    function automatic logic [PFX_W-1:0] trailing_zeros(input logic [ADDR_W-1:0] v);
        logic [PFX_W-1:0] r;
        r = PFX_W'(ADDR_W);
        for (int i = ADDR_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = PFX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [LOG_W-1:0] floor_log2(input logic [CNT_W-1:0] v);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (v[i]) begin
                r = LOG_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/arp_ctrl.sv
// Controller state machine that sequences loading and block emission.
`default_nettype none

module arp_ctrl
    import arp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start && !i_stat.in_zero) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_stat.last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state == S_RUN);

endmodule

`default_nettype wire

FILE: design/arp_dpath.sv
// Datapath holding the current address and remaining count and forming each block.
`default_nettype none

module arp_dpath
    import arp_pkg::*;
#(
    parameter int unsigned RCW = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [ADDR_W-1:0] i_start_address,
    input  wire logic [CNT_W-1:0]  i_address_count,
    output t_stat                  o_stat,
    output logic                   o_valid,
    output logic [ADDR_W-1:0]      o_base_address,
    output logic [PFX_W-1:0]       o_prefix_length,
    output logic                   o_last_block
);

    logic [ADDR_W-1:0] r_addr;
    logic [RCW-1:0]    r_rem;
    logic              r_valid;
    logic [ADDR_W-1:0] r_base;
    logic [PFX_W-1:0]  r_pfx;
    logic              r_last;

    logic [PFX_W-1:0]  w_tz;
    logic [LOG_W-1:0]  w_fl;
    logic [LOG_W-1:0]  w_k;
    logic [RCW-1:0]    w_rem_next;

    assign w_tz       = trailing_zeros(r_addr);
    assign w_fl       = floor_log2(CNT_W'(r_rem));
    assign w_k        = (w_tz < {1'b0, w_fl}) ? w_tz[LOG_W-1:0] : w_fl;
    assign w_rem_next = r_rem - (RCW'(1) << w_k);

    assign o_stat.in_zero = (i_address_count[RCW-1:0] == '0);
    assign o_stat.last    = (w_rem_next == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_rem  <= '0;
        end else if (i_cmd.load) begin
            r_addr <= i_start_address;
            r_rem  <= i_address_count[RCW-1:0];
        end else if (i_cmd.step) begin
            r_addr <= r_addr + (ADDR_W'(1) << w_k);
            r_rem  <= w_rem_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_base <= r_addr;
            r_pfx  <= PFX_W'(ADDR_W) - {1'b0, w_k};
            r_last <= o_stat.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.step;
        end
    end

    assign o_valid         = r_valid;
    assign o_base_address  = r_base;
    assign o_prefix_length = r_pfx;
    assign o_last_block    = r_last;

endmodule

`default_nettype wire

FILE: design/address_range_to_prefix_blocks.sv
// Top level of the address range to prefix block expansion.
//
//  Channel  | Ports                                             | Transfer when
//  ---------+---------------------------------------------------+----------------------
//  request  | start, busy, i_start_address, i_address_count      | start high, busy low
//  result   | o_valid, o_base_address, o_prefix_length, o_last_block | o_valid high
//
// A request is taken and then one prefix block is formed per cycle, so busy
// stays high while the blocks are formed, whose number is at most 2 * COUNT_BITS.
// Each result appears in the cycle after the cycle that formed it, lasting one cycle.
// The per-cycle loop through the trailing-zero and leading-one encoders sets this rate.
// A request whose count is zero is taken but gives no result and leaves busy low.
// Reset is synchronous and active low; results cannot be held off by the receiver.
`default_nettype none

`include "address_range_to_prefix_blocks_defines.svh"

module address_range_to_prefix_blocks
    import arp_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [ADDR_W-1:0] i_start_address,
    input  wire logic [CNT_W-1:0]  i_address_count,
    output logic                   o_valid,
    output logic [ADDR_W-1:0]      o_base_address,
    output logic [PFX_W-1:0]       o_prefix_length,
    output logic                   o_last_block
);

    localparam int unsigned RCW = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;

    t_cmd  w_cmd;
    t_stat w_stat;

    arp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    arp_dpath #(
        .RCW (RCW)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_start_address (i_start_address),
        .i_address_count (i_address_count),
        .o_stat          (w_stat),
        .o_valid         (o_valid),
        .o_base_address  (o_base_address),
        .o_prefix_length (o_prefix_length),
        .o_last_block    (o_last_block)
    );

    `ARP_ASSERT_IMPL(a_prefix_in_range, o_valid, o_prefix_length <= PFX_W'(ADDR_W))
    `ARP_ASSERT_NEXT(a_first_block_follows, $rose(busy), o_valid)
    `ARP_ASSERT_IMPL(a_end_marks_last, $fell(busy), o_valid && o_last_block)
    `ARP_ASSERT_IMPL(a_more_blocks_busy, o_valid && !o_last_block, busy)

endmodule

`default_nettype wire

FILE: dv/address_range_to_prefix_blocks_tb.sv
// Self-checking testbench for the address range to prefix block expansion.
module address_range_to_prefix_blocks_tb;
    import arp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned RANDOM_ITEMS  = 110;
    localparam int unsigned SETTLE_CYCLES = 40;

    typedef struct {
        logic [ADDR_W-1:0] base;
        logic [PFX_W-1:0]  plen;
        logic              last;
    } t_prefix_block;

    class prefix_scoreboard;
        t_prefix_block blocks_due[$];
        int unsigned   errors;

        function new();
            errors = 0;
        endfunction

        function void note_request(input logic [ADDR_W-1:0] addr, input logic [CNT_W-1:0] cnt);
            logic [ADDR_W-1:0] cur;
            logic [CNT_W-1:0]  rem;
            int unsigned       size_log;
            int unsigned       align_log;
            int unsigned       k;
            t_prefix_block     blk;
            cur = addr;
            rem = cnt;
            while (rem != '0) begin
                size_log = 0;
                for (int i = 0; i < CNT_W; i++) begin
                    if (rem[i]) begin
                        size_log = i;
                    end
                end
                align_log = ADDR_W;
                for (int i = ADDR_W - 1; i >= 0; i--) begin
                    if (cur[i]) begin
                        align_log = i;
                    end
                end
                k = (size_log < align_log) ? size_log : align_log;
                rem = rem - (CNT_W'(1) << k);
                blk.base = cur;
                blk.plen = PFX_W'(ADDR_W - k);
                blk.last = (rem == '0);
                blocks_due.push_back(blk);
                cur = cur + (ADDR_W'(1) << k);
            end
        endfunction

        function void check_block(input logic [ADDR_W-1:0] base, input logic [PFX_W-1:0] plen,
                                  input logic last);
            t_prefix_block want;
            if (blocks_due.size() == 0) begin
                $display("%0t ERROR unexpected block: expected none, actual base %h len %0d last %b",
                         $time, base, plen, last);
                errors++;
            end else begin
                want = blocks_due.pop_front();
                if (base !== want.base) begin
                    $display("%0t ERROR base_address: expected %h, actual %h",
                             $time, want.base, base);
                    errors++;
                end
                if (plen !== want.plen) begin
                    $display("%0t ERROR prefix_length: expected %0d, actual %0d",
                             $time, want.plen, plen);
                    errors++;
                end
                if (last !== want.last) begin
                    $display("%0t ERROR last_block: expected %b, actual %b",
                             $time, want.last, last);
                    errors++;
                end
            end
        endfunction

        function int unsigned pending();
            return blocks_due.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [ADDR_W-1:0] i_start_address;
    logic [CNT_W-1:0]  i_address_count;
    logic              o_valid;
    logic [ADDR_W-1:0] o_base_address;
    logic [PFX_W-1:0]  o_prefix_length;
    logic              o_last_block;

    prefix_scoreboard sb = new();
    int unsigned      cycle_count = 0;

    address_range_to_prefix_blocks uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_start_address (i_start_address),
        .i_address_count (i_address_count),
        .o_valid         (o_valid),
        .o_base_address  (o_base_address),
        .o_prefix_length (o_prefix_length),
        .o_last_block    (o_last_block)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_request(i_start_address, i_address_count);
            end
            if (o_valid) begin
                sb.check_block(o_base_address, o_prefix_length, o_last_block);
            end
        end
    end

    task automatic send_range(input logic [ADDR_W-1:0] addr, input logic [CNT_W-1:0] cnt);
        start           = 1'b1;
        i_start_address = addr;
        i_address_count = cnt;
        while (busy) begin
            @(negedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int unsigned cycles);
        start = 1'b0;
        repeat (cycles) begin
            i_start_address = $urandom();
            i_address_count = CNT_W'($urandom());
            @(negedge i_clk);
        end
    endtask

    task automatic drain_blocks();
        start = 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ADDR_W'(32'hFFFF_FFFF - $urandom_range(0, 70000));
            2: return ADDR_W'($urandom()) << $urandom_range(0, 31);
            3: return ADDR_W'($urandom_range(0, 70000));
            default: return ADDR_W'($urandom());
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CNT_W'(1) << $urandom_range(0, CNT_W - 1);
            2: return (CNT_W'(1) << $urandom_range(1, CNT_W)) - CNT_W'(1);
            3, 4: return CNT_W'($urandom_range(1, 64));
            default: return CNT_W'($urandom_range(1, 65535));
        endcase
    endfunction

    initial begin
        int unsigned burst;
        int unsigned sent;
        start           = 1'b0;
        i_start_address = '0;
        i_address_count = '0;
        i_rst_n         = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_range(32'h0000_0000, 16'd1);
        send_range(32'h0000_0000, 16'hFFFF);
        send_range(32'hFFFF_FFFF, 16'd1);
        send_range(32'hFFFF_FFFF, 16'hFFFF);
        send_range(32'h1234_5678, 16'd0);
        send_range(32'hFFFF_FFFF, 16'd0);
        send_range(32'h0000_0001, 16'hFFFF);
        send_range(32'h0000_0001, 16'hFFFE);
        send_range(32'h8000_0000, 16'h8000);
        send_range(32'hFFFF_0000, 16'hFFFF);
        send_range(32'hAAAA_AAAA, 16'h5555);
        send_range(32'h5555_5555, 16'hAAAA);
        send_range(32'hFFFF_FFF0, 16'h0100);
        send_range(32'hFFFF_8001, 16'h7FFF);
        send_range(32'h0000_0000, 16'h8000);
        idle_gap(1);
        send_range(32'h0000_0003, 16'd0);
        idle_gap(2);
        send_range(32'h0000_0003, 16'd5);
        idle_gap(3);
        send_range(32'h7FFF_FFFF, 16'd2);
        send_range(32'h0001_0000, 16'hFFFF);
        drain_blocks();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 7) == 0) ? 20 : $urandom_range(1, 8);
            repeat (burst) begin
                send_range(pick_address(), pick_count());
                sent++;
                if (sent == RANDOM_ITEMS / 2) begin
                    drain_blocks();
                end
            end
            idle_gap($urandom_range(0, 6));
        end

        drain_blocks();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
